// File: rtl/assert_macros.svh
// Assertion macros shared by the max-flow RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BAMF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BAMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BAMF_ASSERT(lbl, clk, rst_n, prop, msg)
`define BAMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/bamf_pkg.sv
// Shared types and constants of the max-flow block.
// No dependencies; imported by bamf_ctrl and the top level.
package bamf_pkg;
  localparam int VTX_W = 6;
  localparam int CAPIN_W = 16;
  localparam int FLOW_W = 22;
  localparam int COST_W = 16;
  localparam int SCALED_W = 38;
  localparam int OP_W = 2;
  localparam int IN_TDATA_W = 32;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_CAP_WIDTH = 16;
  localparam logic [FLOW_W-1:0] FLOW_MAX = '1;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD = 2'd1;
  localparam logic [OP_W-1:0] OP_SOLVE = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SINK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COST = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [VTX_W-1:0] from_vertex;
    logic [VTX_W-1:0] to_vertex;
    logic [CAPIN_W-1:0] capacity;
  } in_item_t;

  typedef struct packed {
    logic valid;
    logic [FLOW_W-1:0] flow;
  } solve_res_t;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_HOLD, ST_INIT, ST_DEQ, ST_DEQW, ST_SCAN, ST_SCANEND,
    ST_BP, ST_BF, ST_BD, ST_AP, ST_AF, ST_AFW, ST_ARW, ST_RES
  } state_t;
endpackage

// File: rtl/bamf_res_mem.sv
// Residual capacity matrix: one write port, one read port, registered read.
// Depends on nothing.
module bamf_res_mem #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/bamf_ctrl.sv
// Sequencer: clear sweep, edge load read-modify-write, BFS search and augmentation.
// Depends on bamf_pkg and assert_macros.svh; drives bamf_res_mem ports.
`include "assert_macros.svh"
module bamf_ctrl #(
  parameter int MAX_VERTICES = 64,
  parameter int CAP_WIDTH = 16
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_fire,
  input  bamf_pkg::in_item_t                          item,
  output logic                                        in_ready,
  input  logic [bamf_pkg::VTX_W-1:0]                  src_cfg,
  input  logic [bamf_pkg::VTX_W-1:0]                  dst_cfg,
  output logic                                        m_we,
  output logic [$clog2(MAX_VERTICES*MAX_VERTICES)-1:0] m_waddr,
  output logic [CAP_WIDTH-1:0]                        m_wdata,
  output logic [$clog2(MAX_VERTICES*MAX_VERTICES)-1:0] m_raddr,
  input  logic [CAP_WIDTH-1:0]                        m_rdata,
  output bamf_pkg::solve_res_t                        res,
  input  logic                                        res_ack
);
  import bamf_pkg::*;

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int AW = $clog2(MAX_VERTICES*MAX_VERTICES);
  localparam int CW = CAP_WIDTH;
  localparam logic [VW:0] TAIL_MAX = (VW+1)'(MAX_VERTICES);
  localparam logic [VW-1:0] LAST_V = VW'(MAX_VERTICES-1);
  localparam logic [AW-1:0] LAST_A = AW'(MAX_VERTICES*MAX_VERTICES-1);
  localparam logic [31:0] CAP_MAX32 = 32'((64'd1 << CAP_WIDTH) - 64'd1);

  function automatic logic [AW-1:0] mat_addr(input logic [VW-1:0] a, input logic [VW-1:0] b);
    mat_addr = AW'(AW'(a) * AW'(MAX_VERTICES) + AW'(b));
  endfunction

  function automatic logic [CW-1:0] add_sat(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    add_sat = s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  state_t state_r, state_nxt;
  logic [VW:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [VW-1:0] cur_r, cur_nxt, v_r, v_nxt, p_r, p_nxt, scan_r, scan_nxt, chk_v_r, chk_v_nxt;
  logic [CW-1:0] bott_r, bott_nxt;
  logic [FLOW_W-1:0] flow_r, flow_nxt;
  logic [MAX_VERTICES-1:0] vis_r, vis_nxt;
  logic chk_r, chk_nxt, e_r, e_nxt, fwd_r, fwd_nxt;
  logic [AW-1:0] e_addr_r, e_addr_nxt, fwd_addr_r, fwd_addr_nxt, clr_r, clr_nxt;
  logic [CW-1:0] e_cap_r, e_cap_nxt, fwd_data_r, fwd_data_nxt;
  logic [OP_W-1:0] hold_r, hold_nxt;

  logic [VW-1:0] parent_mem [MAX_VERTICES];
  logic [VW-1:0] queue_mem [MAX_VERTICES];
  logic p_we, q_we;
  logic [VW-1:0] p_waddr, p_wdata, p_raddr, p_rdata_r, q_waddr, q_wdata, q_raddr, q_rdata_r;

  logic [VW-1:0] src_v, dst_v, from_v, to_v;
  logic ends_ok, edge_ok;
  logic [CW-1:0] cap_c, e_old;
  logic [32:0] fsum;

  assign src_v = VW'(src_cfg);
  assign dst_v = VW'(dst_cfg);
  assign from_v = VW'(item.from_vertex);
  assign to_v = VW'(item.to_vertex);
  assign ends_ok = (32'(src_cfg) < 32'(MAX_VERTICES)) && (32'(dst_cfg) < 32'(MAX_VERTICES))
                   && (src_cfg != dst_cfg);
  assign edge_ok = (32'(item.from_vertex) < 32'(MAX_VERTICES))
                   && (32'(item.to_vertex) < 32'(MAX_VERTICES));
  assign cap_c = (32'(item.capacity) > CAP_MAX32) ? CW'(CAP_MAX32) : CW'(item.capacity);
  assign e_old = (fwd_r && (fwd_addr_r == e_addr_r)) ? fwd_data_r : m_rdata;
  assign fsum = 33'(flow_r) + 33'(bott_r);

  always_ff @(posedge clk) begin
    if (p_we) begin
      parent_mem[p_waddr] <= p_wdata;
    end
    p_rdata_r <= parent_mem[p_raddr];
    if (q_we) begin
      queue_mem[q_waddr] <= q_wdata;
    end
    q_rdata_r <= queue_mem[q_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_r <= '0;
      flow_r <= '0;
      vis_r <= '0;
      chk_r <= 1'b0;
      e_r <= 1'b0;
      fwd_r <= 1'b0;
      head_r <= '0;
      tail_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      flow_r <= flow_nxt;
      vis_r <= vis_nxt;
      chk_r <= chk_nxt;
      e_r <= e_nxt;
      fwd_r <= fwd_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    v_r <= v_nxt;
    p_r <= p_nxt;
    scan_r <= scan_nxt;
    chk_v_r <= chk_v_nxt;
    bott_r <= bott_nxt;
    e_addr_r <= e_addr_nxt;
    e_cap_r <= e_cap_nxt;
    fwd_addr_r <= fwd_addr_nxt;
    fwd_data_r <= fwd_data_nxt;
    hold_r <= hold_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    flow_nxt = flow_r;
    vis_nxt = vis_r;
    chk_nxt = 1'b0;
    chk_v_nxt = chk_v_r;
    e_nxt = 1'b0;
    e_addr_nxt = e_addr_r;
    e_cap_nxt = e_cap_r;
    fwd_nxt = 1'b0;
    fwd_addr_nxt = fwd_addr_r;
    fwd_data_nxt = fwd_data_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    cur_nxt = cur_r;
    v_nxt = v_r;
    p_nxt = p_r;
    scan_nxt = scan_r;
    bott_nxt = bott_r;
    hold_nxt = hold_r;
    in_ready = 1'b0;
    m_we = 1'b0;
    m_waddr = e_addr_r;
    m_wdata = add_sat(e_old, e_cap_r);
    m_raddr = mat_addr(from_v, to_v);
    p_we = 1'b0;
    p_waddr = v_r;
    p_wdata = cur_r;
    p_raddr = v_r;
    q_we = 1'b0;
    q_waddr = tail_r[VW-1:0];
    q_wdata = src_v;
    q_raddr = head_r[VW-1:0];
    res.valid = 1'b0;
    res.flow = flow_r;

    // pending edge write, in the cycle after its read
    if (e_r) begin
      m_we = 1'b1;
      fwd_nxt = 1'b1;
      fwd_addr_nxt = e_addr_r;
      fwd_data_nxt = m_wdata;
    end

    // scan check stage
    if (chk_r && (m_rdata != '0) && !vis_r[chk_v_r]) begin
      vis_nxt[chk_v_r] = 1'b1;
      p_we = 1'b1;
      p_waddr = chk_v_r;
      p_wdata = cur_r;
      if (tail_r < TAIL_MAX) begin
        q_we = 1'b1;
        q_wdata = chk_v_r;
        tail_nxt = tail_r + 1'b1;
      end
    end

    case (state_r)
      ST_CLR: begin
        m_we = 1'b1;
        m_waddr = clr_r;
        m_wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_A) begin
          clr_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          hold_nxt = item.op;
          if (item.op == OP_ADD) begin
            e_nxt = edge_ok;
            e_addr_nxt = mat_addr(from_v, to_v);
            e_cap_nxt = cap_c;
          end else if (item.op == OP_CLEAR || item.op == OP_SOLVE) begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (hold_r == OP_CLEAR) begin
          flow_nxt = '0;
          state_nxt = ST_CLR;
        end else begin
          state_nxt = ends_ok ? ST_INIT : ST_RES;
        end
      end
      ST_INIT: begin
        vis_nxt = '0;
        vis_nxt[src_v] = 1'b1;
        p_we = 1'b1;
        p_waddr = src_v;
        p_wdata = src_v;
        q_we = 1'b1;
        q_waddr = '0;
        q_wdata = src_v;
        head_nxt = '0;
        tail_nxt = (VW+1)'(1);
        state_nxt = ST_DEQ;
      end
      ST_DEQ: begin
        state_nxt = (head_r < tail_r) ? ST_DEQW : ST_RES;
      end
      ST_DEQW: begin
        cur_nxt = q_rdata_r;
        head_nxt = head_r + 1'b1;
        if (q_rdata_r == dst_v) begin
          v_nxt = dst_v;
          bott_nxt = '1;
          state_nxt = ST_BP;
        end else begin
          scan_nxt = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        m_raddr = mat_addr(cur_r, scan_r);
        chk_nxt = 1'b1;
        chk_v_nxt = scan_r;
        scan_nxt = scan_r + 1'b1;
        if (scan_r == LAST_V) begin
          state_nxt = ST_SCANEND;
        end
      end
      ST_SCANEND: begin
        state_nxt = ST_DEQ;
      end
      ST_BP: begin
        p_raddr = v_r;
        state_nxt = ST_BF;
      end
      ST_BF: begin
        p_nxt = p_rdata_r;
        m_raddr = mat_addr(p_rdata_r, v_r);
        state_nxt = ST_BD;
      end
      ST_BD: begin
        if (m_rdata < bott_r) begin
          bott_nxt = m_rdata;
        end
        v_nxt = p_r;
        state_nxt = ST_BP;
        if (p_r == src_v) begin
          v_nxt = dst_v;
          state_nxt = ST_AP;
        end
      end
      ST_AP: begin
        p_raddr = v_r;
        state_nxt = ST_AF;
      end
      ST_AF: begin
        p_nxt = p_rdata_r;
        m_raddr = mat_addr(p_rdata_r, v_r);
        state_nxt = ST_AFW;
      end
      ST_AFW: begin
        m_we = 1'b1;
        m_waddr = mat_addr(p_r, v_r);
        m_wdata = m_rdata - bott_r;
        m_raddr = mat_addr(v_r, p_r);
        state_nxt = ST_ARW;
      end
      ST_ARW: begin
        m_we = 1'b1;
        m_waddr = mat_addr(v_r, p_r);
        m_wdata = add_sat(m_rdata, bott_r);
        v_nxt = p_r;
        state_nxt = ST_AP;
        if (p_r == src_v) begin
          flow_nxt = (fsum > 33'(FLOW_MAX)) ? FLOW_MAX : FLOW_W'(fsum);
          state_nxt = ST_INIT;
        end
      end
      ST_RES: begin
        res.valid = 1'b1;
        if (res_ack) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `BAMF_ASSERT(a_chk_in_scan, clk, rst_n, !chk_r || state_r == ST_SCAN || state_r == ST_SCANEND, "scan check outside scan")
  `BAMF_ASSERT(a_queue_order, clk, rst_n, head_r <= tail_r && tail_r <= TAIL_MAX, "queue pointers out of order")
  `BAMF_ASSERT(a_edge_idle, clk, rst_n, !e_r || state_r == ST_IDLE || state_r == ST_HOLD, "edge write during solve or clear")
endmodule

// File: rtl/bfs_augmenting_max_flow.sv
// Top level of the max-flow engine: stream ports, configuration registers and result register.
// Depends on bamf_pkg, bamf_ctrl, bamf_res_mem and assert_macros.svh.
//
// Edge items (op 1) are taken one per cycle while the engine is idle; a read-modify-write
// of the residual matrix memory with write forwarding makes back-to-back loads to one cell
// add up. Reset and a clear item start a clearing pass that writes zero to every cell of
// the matrix, during which no item is taken. A solve item runs breadth-first searches on the
// single read port of the matrix memory: each dequeued vertex scans its whole matrix row, and
// each path found is walked back from the sink once for bottleneck and once for update.
// The result item leaves through an output register; a new item is taken while it waits.
`include "assert_macros.svh"
module bfs_augmenting_max_flow #(
  parameter int MAX_VERTICES = bamf_pkg::DEF_MAX_VERTICES,
  parameter int CAP_WIDTH = bamf_pkg::DEF_CAP_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // op[1:0], from_vertex[7:2], to_vertex[13:8], capacity[29:14], zero pad
  input  logic [bamf_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // max_flow[21:0], scaled_cost[59:22], zero pad
  output logic [bamf_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_we,
  input  logic [bamf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bamf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import bamf_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES*MAX_VERTICES);

  logic [VTX_W-1:0] src_r, dst_r;
  logic [COST_W-1:0] cost_r;
  logic out_valid_r;
  logic [FLOW_W-1:0] out_flow_r;
  logic [SCALED_W-1:0] out_cost_r;
  in_item_t item;
  solve_res_t res;
  logic res_ack, in_fire;
  logic m_we;
  logic [AW-1:0] m_waddr, m_raddr;
  logic [CAP_WIDTH-1:0] m_wdata, m_rdata;

  assign item.op = in_tdata[1:0];
  assign item.from_vertex = in_tdata[7:2];
  assign item.to_vertex = in_tdata[13:8];
  assign item.capacity = in_tdata[29:14];
  assign in_fire = in_tvalid && in_tready;
  assign res_ack = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata = {4'b0, out_cost_r, out_flow_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= '0;
      dst_r <= 6'd63;
      cost_r <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SRC: src_r <= cfg_wdata[VTX_W-1:0];
        CFG_SINK: dst_r <= cfg_wdata[VTX_W-1:0];
        CFG_COST: cost_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_ack) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ack) begin
      out_flow_r <= res.flow;
      out_cost_r <= SCALED_W'(res.flow) * SCALED_W'(cost_r);
    end
  end

  bamf_ctrl #(
    .MAX_VERTICES(MAX_VERTICES),
    .CAP_WIDTH(CAP_WIDTH)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_fire(in_fire),
    .item(item),
    .in_ready(in_tready),
    .src_cfg(src_r),
    .dst_cfg(dst_r),
    .m_we(m_we),
    .m_waddr(m_waddr),
    .m_wdata(m_wdata),
    .m_raddr(m_raddr),
    .m_rdata(m_rdata),
    .res(res),
    .res_ack(res_ack)
  );

  bamf_res_mem #(
    .DEPTH(MAX_VERTICES*MAX_VERTICES),
    .WIDTH(CAP_WIDTH)
  ) u_mem (
    .clk(clk),
    .we(m_we),
    .waddr(m_waddr),
    .wdata(m_wdata),
    .raddr(m_raddr),
    .rdata(m_rdata)
  );

  `BAMF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_r && !out_tready, out_valid_r && $stable(out_flow_r), "result dropped under stall")
  `BAMF_ASSERT(a_res_no_loss, clk, rst_n, !(res.valid && !res_ack) || out_valid_r, "result blocked without pending output")
  `BAMF_ASSERT_NEXT(a_res_taken, clk, rst_n, res.valid && res_ack, out_valid_r, "result not registered")
endmodule
